/* hdl/pidc_pkg.sv */
// shared types and constants for the two-mode pid controller
package pidc_pkg;

    localparam int ErrW      = 17;
    localparam int IntegW    = 32;
    localparam int GainW     = 16;
    localparam int LimitW    = 15;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MODE      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_OUT_LIMIT = 3'd4;

    // controller forms
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    // register reset values
    localparam logic             RST_MODE      = MODE_INCREMENTAL;
    localparam logic [GainW-1:0] RST_GAIN_P    = 16'd768;
    localparam logic [GainW-1:0] RST_GAIN_I    = 16'd0;
    localparam logic [GainW-1:0] RST_GAIN_D    = 16'd0;
    localparam logic [LimitW-1:0] RST_OUT_LIMIT = 15'd7200;

    typedef struct packed {
        logic signed [15:0] measured;
        logic signed [15:0] target;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic              mode;
        logic [GainW-1:0]  gain_p;
        logic [GainW-1:0]  gain_i;
        logic [GainW-1:0]  gain_d;
        logic [LimitW-1:0] out_limit;
    } cfg_t;

endpackage

/* hdl/pidc_core.sv */
// pid arithmetic for one sample plus the error history and integral
module pidc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  pidc_pkg::in_item_t   item,
    input  pidc_pkg::cfg_t       cfg,
    output pidc_pkg::out_item_t  result
);
    import pidc_pkg::*;

    localparam int SumW = 51;
    localparam int RndW = SumW - 8;

    logic signed [ErrW-1:0]   err_last_reg, err_last_next;
    logic signed [ErrW-1:0]   err_prev_reg, err_prev_next;
    logic signed [IntegW-1:0] integ_reg, integ_next;

    logic signed [ErrW-1:0]   err;
    logic signed [ErrW:0]     diff1;
    logic signed [ErrW+1:0]   diff2;
    logic signed [IntegW:0]   acc_wide;
    logic signed [IntegW-1:0] acc;
    logic signed [GainW:0]    kp_s, ki_s, kd_s;
    logic signed [33:0]       prod_p;
    logic signed [48:0]       prod_i;
    logic signed [35:0]       prod_d;
    logic signed [SumW-1:0]   sum;
    logic signed [SumW-1:0]   sum_bias;
    logic signed [RndW-1:0]   rnd;
    logic signed [RndW-1:0]   lim_pos, lim_neg;
    logic signed [15:0]       drive;
    logic                     sat;

    assign err   = ErrW'(item.target) - ErrW'(item.measured);
    assign diff1 = (ErrW+1)'(err) - (ErrW+1)'(err_last_reg);
    assign diff2 = (ErrW+2)'(err) - ((ErrW+2)'(err_last_reg) <<< 1) + (ErrW+2)'(err_prev_reg);

    // saturating integral, includes the current error
    assign acc_wide = (IntegW+1)'(integ_reg) + (IntegW+1)'(err);
    always_comb begin
        if (acc_wide[IntegW] != acc_wide[IntegW-1]) begin
            acc = acc_wide[IntegW] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
        end else begin
            acc = acc_wide[IntegW-1:0];
        end
    end

    assign kp_s = signed'({1'b0, cfg.gain_p});
    assign ki_s = signed'({1'b0, cfg.gain_i});
    assign kd_s = signed'({1'b0, cfg.gain_d});

    always_comb begin
        if (cfg.mode == MODE_POSITIONAL) begin
            prod_p = 34'(kp_s) * 34'(err);
            prod_i = 49'(ki_s) * 49'(acc);
            prod_d = 36'(kd_s) * 36'(diff1);
        end else begin
            prod_p = 34'(kp_s) * 34'(diff1);
            prod_i = 49'(ki_s) * 49'(err);
            prod_d = 36'(kd_s) * 36'(diff2);
        end
    end

    assign sum      = SumW'(prod_p) + SumW'(prod_i) + SumW'(prod_d);
    assign sum_bias = sum + SumW'(128);
    // floor division by 256
    assign rnd      = sum_bias[SumW-1:8];

    assign lim_pos = signed'(RndW'(cfg.out_limit));
    assign lim_neg = -lim_pos;

    always_comb begin
        drive = rnd[15:0];
        sat   = 1'b0;
        if (cfg.mode == MODE_POSITIONAL) begin
            if (rnd > RndW'(32767)) begin
                drive = 16'sh7fff;
                sat   = 1'b1;
            end else if (rnd < -RndW'(32768)) begin
                drive = -16'sh8000;
                sat   = 1'b1;
            end
        end else begin
            if (rnd > lim_pos) begin
                drive = lim_pos[15:0];
                sat   = 1'b1;
            end else if (rnd < lim_neg) begin
                drive = lim_neg[15:0];
                sat   = 1'b1;
            end
        end
    end

    assign result.drive     = drive;
    assign result.saturated = sat;

    always_comb begin
        err_last_next = err_last_reg;
        err_prev_next = err_prev_reg;
        integ_next    = integ_reg;
        if (step) begin
            err_last_next = err;
            err_prev_next = err_last_reg;
            if (cfg.mode == MODE_POSITIONAL) begin
                integ_next = acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_last_reg <= '0;
            err_prev_reg <= '0;
            integ_reg    <= '0;
        end else begin
            err_last_reg <= err_last_next;
            err_prev_reg <= err_prev_next;
            integ_reg    <= integ_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hist_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(err_last_reg) && $stable(err_prev_reg) && $stable(integ_reg))
        else $error("error history moved without a sample");
    a_pos_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (cfg.mode == MODE_POSITIONAL) && sat
        |-> (drive == 16'sh7fff) || (drive == -16'sh8000))
        else $error("positional saturation not at a rail");
    a_inc_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (cfg.mode == MODE_INCREMENTAL)
        |-> (RndW'(drive) <= lim_pos) && (RndW'(drive) >= lim_neg))
        else $error("incremental drive beyond the limit");
`endif

endmodule

/* hdl/pid_controller_two_mode.sv */
// top level of the two-mode pid controller with handshake and configuration registers
//
//  channel   ports                          direction  content
//  input     s_valid s_ready s_data         in         measured, target
//  result    m_valid m_ready m_data         out        drive, saturated
//  config    cfg_valid cfg_ready cfg_index  in         register index and write data
//            cfg_wdata
//
// an item waits in the input register after its transfer until the result register is
// free, then goes through the pid arithmetic into the result register, whose valid
// flag drives m_valid
// a new item can be taken every cycle while m_ready stays high; the sustained rate is then one item per cycle
// reset loads the register defaults and clears error history, integral and both valid flags
// a stalled result holds the result register; the input register still takes one
// more item, then s_ready drops until the result is taken
// config writes are always accepted (cfg_ready is tied high)
module pid_controller_two_mode (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pidc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pidc_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidc_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [pidc_pkg::CfgDataW-1:0]     cfg_wdata
);
    import pidc_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    out_item_t core_result;
    logic      advance;
    logic      step;

    // result register free, or its item leaves this cycle
    assign advance   = !out_valid_reg || m_ready;
    // the input register hands its item to the result register
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:      cfg_next.mode      = cfg_wdata[0];
                CFG_GAIN_P:    cfg_next.gain_p    = cfg_wdata;
                CFG_GAIN_I:    cfg_next.gain_i    = cfg_wdata;
                CFG_GAIN_D:    cfg_next.gain_d    = cfg_wdata;
                CFG_OUT_LIMIT: cfg_next.out_limit = cfg_wdata[LimitW-1:0];
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    // valid flags of the two stages
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= RST_MODE;
            cfg_reg.gain_p    <= RST_GAIN_P;
            cfg_reg.gain_i    <= RST_GAIN_I;
            cfg_reg.gain_d    <= RST_GAIN_D;
            cfg_reg.out_limit <= RST_OUT_LIMIT;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step) begin
            out_data_reg <= core_result;
        end
    end

    // arithmetic and error history; history moves on each step
    pidc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

endmodule

/* bench/tb.sv */
// self-checking testbench for the two-mode pid controller
module tb;
    import pidc_pkg::*;

    // run limits and pacing
    localparam int LimitCycles  = 100000;  // several times a run with the longest stalls
    localparam int HoldCycles   = 300;     // long result-side hold-off
    localparam int HoldAfter    = 100;     // start the hold-off after this many input transfers
    localparam int SettleCycles = 8;       // pipeline is two deep, so this is plenty
    localparam int ReportMax    = 10;

    // arithmetic bounds for the predictor
    localparam longint IntegMax = (64'sd1 <<< (IntegW - 1)) - 64'sd1;
    localparam longint IntegMin = -(64'sd1 <<< (IntegW - 1));
    localparam longint DriveMax = 64'sd32767;
    localparam longint DriveMin = -64'sd32768;

    // an index that maps to no register, the write must be dropped
    localparam logic [CfgIdxW-1:0] CfgNoReg = '1;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;

    pid_controller_two_mode dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // controller copy kept by the testbench: registers and error history
    cfg_t                      ctl_cfg;
    logic signed [ErrW-1:0]    err_d1;
    logic signed [ErrW-1:0]    err_d2;
    logic signed [IntegW-1:0]  err_sum;

    in_item_t  sample_q[$];        // samples waiting to be offered
    out_item_t drive_expect_q[$];  // predicted results, oldest first

    int samples_queued = 0;
    int samples_taken  = 0;
    int results_seen   = 0;
    int mismatch_cnt   = 0;

    // handshake flags sampled at the rising edge, read at the falling edge
    bit s_fire   = 1'b0;
    bit cfg_fire = 1'b0;

    bit quiet     = 1'b0;  // no idling on either side while set
    bit hold_done = 1'b0;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // cycle-count watchdog
    initial begin : watchdog
        int n;
        n = 0;
        while (n < LimitCycles) begin
            @(posedge aclk);
            n++;
        end
        $display("pid_controller_two_mode verification failed");
        $finish;
    end

    // register write into the local copy, unknown indexes are ignored
    task automatic apply_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        case (idx)
            CFG_MODE:      ctl_cfg.mode      = val[0];
            CFG_GAIN_P:    ctl_cfg.gain_p    = val;
            CFG_GAIN_I:    ctl_cfg.gain_i    = val;
            CFG_GAIN_D:    ctl_cfg.gain_d    = val;
            CFG_OUT_LIMIT: ctl_cfg.out_limit = val[LimitW-1:0];
            default: ;
        endcase
    endtask

    // one controller update: advances the history and integral, returns the result
    function automatic out_item_t pid_update(in_item_t smp);
        longint    err, e1, e2, kp, ki, kd, acc, sum, rnd, lim;
        out_item_t res;
        err = longint'(smp.target) - longint'(smp.measured);
        e1  = longint'(err_d1);
        e2  = longint'(err_d2);
        kp  = longint'(ctl_cfg.gain_p);
        ki  = longint'(ctl_cfg.gain_i);
        kd  = longint'(ctl_cfg.gain_d);
        res.saturated = 1'b0;
        if (ctl_cfg.mode == MODE_POSITIONAL) begin
            // integral takes the current error first and sticks at the 32-bit bounds
            acc = longint'(err_sum) + err;
            if (acc > IntegMax) begin
                acc = IntegMax;
            end else if (acc < IntegMin) begin
                acc = IntegMin;
            end
            err_sum = acc[IntegW-1:0];
            sum = kp * err + ki * acc + kd * (err - e1);
            rnd = (sum + 64'sd128) >>> 8;  // gains are q8.8: drop the 8 fraction bits, round half up
            if (rnd > DriveMax) begin
                rnd = DriveMax;
                res.saturated = 1'b1;
            end else if (rnd < DriveMin) begin
                rnd = DriveMin;
                res.saturated = 1'b1;
            end
        end else begin
            lim = longint'(ctl_cfg.out_limit);
            sum = kp * (err - e1) + ki * err + kd * (err - 2 * e1 + e2);
            rnd = (sum + 64'sd128) >>> 8;
            if (rnd > lim) begin
                rnd = lim;
                res.saturated = 1'b1;
            end else if (rnd < -lim) begin
                rnd = -lim;
                res.saturated = 1'b1;
            end
        end
        // history shifts in both forms
        err_d2 = err_d1;
        err_d1 = err[ErrW-1:0];
        res.drive = rnd[15:0];
        return res;
    endfunction

    // rising edge: record transfers, predict, compare results
    always @(posedge aclk) begin : monitor
        out_item_t want;
        s_fire   = aresetn && s_valid && s_ready;
        cfg_fire = aresetn && cfg_valid && cfg_ready;
        if (cfg_fire) begin
            apply_cfg(cfg_index, cfg_wdata);
        end
        if (s_fire) begin
            drive_expect_q.push_back(pid_update(s_data));
            samples_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (drive_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= ReportMax) begin
                    $display("result %0d with nothing expected: drive %0d saturated %0b",
                             results_seen, m_data.drive, m_data.saturated);
                end
            end else begin
                want = drive_expect_q.pop_front();
                if (m_data.drive !== want.drive || m_data.saturated !== want.saturated) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= ReportMax) begin
                        $display("result %0d: drive exp %0d got %0d, saturated exp %0b got %0b",
                                 results_seen, want.drive, m_data.drive,
                                 want.saturated, m_data.saturated);
                    end
                end
            end
            results_seen++;
        end
    end

    // sample driver: presents the next pending sample once the bus is free
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                s_data  <= sample_q.pop_front();
                s_valid <= 1'b1;
                // idle burst after this transfer
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall bursts plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && samples_taken >= HoldAfter) begin
            // sender keeps going, so the block fills and drops s_ready
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic wr_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(logic mode, logic [GainW-1:0] kp, logic [GainW-1:0] ki,
                           logic [GainW-1:0] kd, logic [LimitW-1:0] lim);
        wr_reg(CFG_MODE, CfgDataW'(mode));
        wr_reg(CFG_GAIN_P, kp);
        wr_reg(CFG_GAIN_I, ki);
        wr_reg(CFG_GAIN_D, kd);
        wr_reg(CFG_OUT_LIMIT, CfgDataW'(lim));
    endtask

    task automatic queue_sample(in_item_t smp);
        sample_q.push_back(smp);
        samples_queued++;
    endtask

    task automatic queue_pair(logic signed [15:0] meas, logic signed [15:0] tgt);
        in_item_t smp;
        smp.measured = meas;
        smp.target   = tgt;
        queue_sample(smp);
    endtask

    function automatic logic [GainW-1:0] rand_gain();
        case ($urandom_range(0, 2))
            0: return GainW'($urandom_range(0, 511));
            1: return GainW'($urandom_range(0, 4095));
            default: return GainW'($urandom_range(0, 65535));
        endcase
    endfunction

    // half fully random, half target near measured so outputs stay in range
    function automatic in_item_t rand_sample();
        in_item_t smp;
        int       spread, tgt;
        smp.measured = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 0) begin
            smp.target = 16'($urandom_range(0, 65535));
        end else begin
            case ($urandom_range(0, 2))
                0: spread = 8;
                1: spread = 300;
                default: spread = 6000;
            endcase
            tgt = int'(smp.measured) + int'($urandom_range(0, 2 * spread)) - spread;
            if (tgt > 32767) tgt = 32767;
            if (tgt < -32768) tgt = -32768;
            smp.target = tgt[15:0];
        end
        return smp;
    endfunction

    task automatic queue_random(int n);
        int j;
        for (j = 0; j < n; j++) begin
            queue_sample(rand_sample());
        end
    endtask

    // every sample taken, every result back, then let the pipeline settle
    task automatic wait_idle();
        while (samples_taken != samples_queued || drive_expect_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SettleCycles) @(negedge aclk);
    endtask

    initial begin : stimulus
        int k;
        ctl_cfg.mode      = RST_MODE;
        ctl_cfg.gain_p    = RST_GAIN_P;
        ctl_cfg.gain_i    = RST_GAIN_I;
        ctl_cfg.gain_d    = RST_GAIN_D;
        ctl_cfg.out_limit = RST_OUT_LIMIT;
        err_d1  = '0;
        err_d2  = '0;
        err_sum = '0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, incremental form: error extremes and history
        quiet = 1'b0;
        queue_pair(16'sd0, 16'sd0);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_pair(16'sd32767, -16'sd32768);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_pair(16'sd32767, 16'sd32767);
        queue_pair(-16'sd32768, -16'sd32768);
        wait_idle();

        // positional form, widest limit; the long hold-off lands in here
        cfg_all(MODE_POSITIONAL, 16'd256, 16'd16, 16'd128, 15'd32767);
        queue_pair(16'sd100, 16'sd150);
        queue_pair(16'sd150, 16'sd100);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_pair(16'sd32767, -16'sd32768);
        queue_pair(16'sd0, 16'sd0);
        queue_random(150);
        wait_idle();

        // incremental with all gains at maximum and a zero limit
        cfg_all(MODE_INCREMENTAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0);
        wr_reg(CfgNoReg, 16'($urandom_range(0, 65535)));
        queue_pair(16'sd5, 16'sd5);
        queue_pair(16'sd0, 16'sd1);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_pair(16'sd32767, -16'sd32768);
        queue_random(60);
        wait_idle();

        // positional with all gains at zero, the integral still runs
        cfg_all(MODE_POSITIONAL, 16'd0, 16'd0, 16'd0, 15'($urandom_range(0, 32767)));
        queue_pair(16'sd1, -16'sd1);
        queue_pair(-16'sd32768, 16'sd32767);
        queue_random(20);
        wait_idle();

        // random settings, mode switches keep the history
        for (k = 0; k < 4; k++) begin
            quiet = ($urandom_range(0, 3) == 0);
            cfg_all($urandom_range(0, 1) ? MODE_INCREMENTAL : MODE_POSITIONAL,
                    rand_gain(), rand_gain(), rand_gain(), 15'($urandom_range(0, 32767)));
            queue_random(100);
            wait_idle();
        end

        // closing stretch without any idling
        quiet = 1'b1;
        cfg_all(MODE_INCREMENTAL, rand_gain(), rand_gain(), rand_gain(),
                15'($urandom_range(0, 32767)));
        queue_random(100);
        wait_idle();
        repeat (SettleCycles) @(negedge aclk);

        if (mismatch_cnt == 0 && drive_expect_q.size() == 0) begin
            $display("pid_controller_two_mode verification clean");
        end else begin
            $display("pid_controller_two_mode verification failed");
        end
        $finish;
    end

endmodule
